@@ hdl/lidar_point_camera_projection_filter_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the lidar point camera projection filter
// Concurrent checks compiled in for simulation, empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POINT_CAMERA_PROJECTION_FILTER_UNIT_MACROS_SVH
`define LIDAR_POINT_CAMERA_PROJECTION_FILTER_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted
`define LPCP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lpcp: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted
`define LPCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpcp: next-cycle check failed");
`else
`define LPCP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LPCP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/lpcp_pkg.sv @@
// ----------------------------------------------------------------------------
// lpcp_pkg
// Shared widths, register indexes, stage types and helpers of the projector.
// ----------------------------------------------------------------------------
package lpcp_pkg;

	// Field and datapath widths
	localparam int COORD_W     = 32;                 // Q16.16 coordinate
	localparam int COEF_W      = 32;                 // Q16.16 coefficient
	localparam int PROD_W      = COORD_W + COEF_W;   // exact Q32.32 product
	localparam int Y_W         = PROD_W + 2;         // sum of four products
	localparam int REM_W       = Y_W - 1;            // non-negative magnitude
	localparam int QUOT_W      = 14;                 // quotient bits incl. overflow range
	localparam int DSH_W       = REM_W + QUOT_W;     // shifted divisor compare width
	localparam int DIM_W       = 14;
	localparam int PIX_W       = 13;
	localparam int ONE_SHIFT   = 16;                 // 1.0 in Q16.16
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 64;
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 128;

	localparam logic [DIM_W-1:0] MAX_IMAGE_DIM = DIM_W'(8192);
	localparam logic [DIM_W-1:0] WIDTH_RESET   = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RESET  = DIM_W'(480);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW0_C01 = 4'd0,
		CFG_ROW0_C23 = 4'd1,
		CFG_ROW1_C01 = 4'd2,
		CFG_ROW1_C23 = 4'd3,
		CFG_ROW2_C01 = 4'd4,
		CFG_ROW2_C23 = 4'd5,
		CFG_WIDTH    = 4'd6,
		CFG_HEIGHT   = 4'd7
	} cfg_reg_t;

	// 3x4 projection matrix, [row][col]
	typedef logic [2:0][3:0][COEF_W-1:0] coef_mat_t;

	// Point payload carried alongside the arithmetic
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      cend;
	} point_t;

	// Projection front end to divider
	typedef struct packed {
		logic             vld;
		point_t           pt;
		logic             ok;      // depth positive, both numerators non-negative
		logic             ovf_c;   // column quotient beyond the quotient range
		logic             ovf_r;
		logic [REM_W-1:0] n_c;
		logic [REM_W-1:0] n_r;
		logic [REM_W-1:0] d;
	} div_in_t;

	// Divider to output stage
	typedef struct packed {
		logic              vld;
		point_t            pt;
		logic              ok;
		logic              ovf_c;
		logic              ovf_r;
		logic [QUOT_W-1:0] q_c;
		logic [QUOT_W-1:0] q_r;
	} div_out_t;

	// Saturate an image dimension to the largest supported size
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		return (v > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : v;
	endfunction

endpackage

@@ hdl/lpcp_proj.sv @@
// ----------------------------------------------------------------------------
// lpcp_proj
// Matrix-vector front end: products, two adder levels, sign and range checks.
// ----------------------------------------------------------------------------
module lpcp_proj (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  lpcp_pkg::coef_mat_t coef,
	input  logic               in_vld,
	input  lpcp_pkg::point_t   in_pt,
	output lpcp_pkg::div_in_t  dout
);
	import lpcp_pkg::*;

	logic signed [COORD_W-1:0] pt [3];

	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	point_t                   pt_s1, pt_s2, pt_s3, pt_s4;
	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic signed [Y_W-1:0]    psum_a_s2 [3];
	logic signed [Y_W-1:0]    psum_b_s2 [3];
	logic signed [Y_W-1:0]    y_s3 [3];
	logic signed [Y_W-1:0]    offs [3];

	logic                     ok_s4, ovf_c_s4, ovf_r_s4;
	logic [REM_W-1:0]         n_c_s4, n_r_s4, d_s4;

	logic                     ok_n, ovf_c_n, ovf_r_n;

	assign pt[0] = in_pt.x;
	assign pt[1] = in_pt.y;
	assign pt[2] = in_pt.z;

	// Valid bits travel with the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Carry the point along
	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s1 <= in_pt;
			pt_s2 <= pt_s1;
			pt_s3 <= pt_s2;
			pt_s4 <= pt_s3;
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		// Translation term: coefficient times 1.0
		assign offs[r] = {{(Y_W-COEF_W-ONE_SHIFT){coef[r][3][COEF_W-1]}},
			coef[r][3], {ONE_SHIFT{1'b0}}};

		// Stage 1: exact products
		for (genvar c = 0; c < 3; c++) begin : g_col
			always_ff @(posedge clk) begin
				if (adv) begin
					prod_s1[r][c] <= $signed(coef[r][c]) * pt[c];
				end
			end
		end

		// Stages 2 and 3: sum the row in two adder levels
		always_ff @(posedge clk) begin
			if (adv) begin
				psum_a_s2[r] <= Y_W'(prod_s1[r][0]) + Y_W'(prod_s1[r][1]);
				psum_b_s2[r] <= Y_W'(prod_s1[r][2]) + offs[r];
				y_s3[r]      <= psum_a_s2[r] + psum_b_s2[r];
			end
		end
	end

	// Stage 4: front-of-camera test and quotient range check
	always_comb begin
		ok_n    = !y_s3[2][Y_W-1] && (y_s3[2] != '0) &&
			!y_s3[0][Y_W-1] && !y_s3[1][Y_W-1];
		ovf_c_n = {{QUOT_W{1'b0}}, y_s3[0][REM_W-1:0]} >=
			{y_s3[2][REM_W-1:0], {QUOT_W{1'b0}}};
		ovf_r_n = {{QUOT_W{1'b0}}, y_s3[1][REM_W-1:0]} >=
			{y_s3[2][REM_W-1:0], {QUOT_W{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s4    <= ok_n;
			ovf_c_s4 <= ovf_c_n;
			ovf_r_s4 <= ovf_r_n;
			n_c_s4   <= y_s3[0][REM_W-1:0];
			n_r_s4   <= y_s3[1][REM_W-1:0];
			d_s4     <= y_s3[2][REM_W-1:0];
		end
	end

	assign dout = '{vld: vld_s4, pt: pt_s4, ok: ok_s4, ovf_c: ovf_c_s4, ovf_r: ovf_r_s4,
		n_c: n_c_s4, n_r: n_r_s4, d: d_s4};

endmodule

@@ hdl/lpcp_div_pipe.sv @@
// ----------------------------------------------------------------------------
// lpcp_div_pipe
// Restoring divider, one quotient bit per stage, column and row side by side.
// ----------------------------------------------------------------------------
module lpcp_div_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  lpcp_pkg::div_in_t  din,
	output lpcp_pkg::div_out_t dout
);
	import lpcp_pkg::*;

	logic              vld_s   [QUOT_W];
	point_t            pt_s    [QUOT_W];
	logic              ok_s    [QUOT_W];
	logic              ovf_c_s [QUOT_W];
	logic              ovf_r_s [QUOT_W];
	logic [REM_W-1:0]  rem_c_s [QUOT_W];
	logic [REM_W-1:0]  rem_r_s [QUOT_W];
	logic [REM_W-1:0]  d_s     [QUOT_W];
	logic [QUOT_W-1:0] q_c_s   [QUOT_W];
	logic [QUOT_W-1:0] q_r_s   [QUOT_W];

	for (genvar i = 0; i < QUOT_W; i++) begin : g_step
		localparam int B = QUOT_W - 1 - i;

		logic              vld_in, ok_in, ovf_c_in, ovf_r_in;
		point_t            pt_in;
		logic [REM_W-1:0]  rem_c_in, rem_r_in, d_in;
		logic [QUOT_W-1:0] q_c_in, q_r_in;
		logic [DSH_W-1:0]  sub_d, ext_c, ext_r, dif_c, dif_r;
		logic              ge_c, ge_r;

		// Stage input: divider entry or previous step
		if (i == 0) begin : g_first
			assign vld_in   = din.vld;
			assign pt_in    = din.pt;
			assign ok_in    = din.ok;
			assign ovf_c_in = din.ovf_c;
			assign ovf_r_in = din.ovf_r;
			assign rem_c_in = din.n_c;
			assign rem_r_in = din.n_r;
			assign d_in     = din.d;
			assign q_c_in   = '0;
			assign q_r_in   = '0;
		end else begin : g_next
			assign vld_in   = vld_s[i-1];
			assign pt_in    = pt_s[i-1];
			assign ok_in    = ok_s[i-1];
			assign ovf_c_in = ovf_c_s[i-1];
			assign ovf_r_in = ovf_r_s[i-1];
			assign rem_c_in = rem_c_s[i-1];
			assign rem_r_in = rem_r_s[i-1];
			assign d_in     = d_s[i-1];
			assign q_c_in   = q_c_s[i-1];
			assign q_r_in   = q_r_s[i-1];
		end

		// Trial subtract of the shifted divisor
		assign sub_d = {{QUOT_W{1'b0}}, d_in} << B;
		assign ext_c = {{QUOT_W{1'b0}}, rem_c_in};
		assign ext_r = {{QUOT_W{1'b0}}, rem_r_in};
		assign ge_c  = ext_c >= sub_d;
		assign ge_r  = ext_r >= sub_d;
		assign dif_c = ext_c - sub_d;
		assign dif_r = ext_r - sub_d;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vld_in;
			end
		end

		// Keep the remainder and set this quotient bit
		always_ff @(posedge clk) begin
			if (adv) begin
				pt_s[i]    <= pt_in;
				ok_s[i]    <= ok_in;
				ovf_c_s[i] <= ovf_c_in;
				ovf_r_s[i] <= ovf_r_in;
				d_s[i]     <= d_in;
				rem_c_s[i] <= ge_c ? dif_c[REM_W-1:0] : rem_c_in;
				rem_r_s[i] <= ge_r ? dif_r[REM_W-1:0] : rem_r_in;
				q_c_s[i]   <= q_c_in | (QUOT_W'(ge_c) << B);
				q_r_s[i]   <= q_r_in | (QUOT_W'(ge_r) << B);
			end
		end
	end

	assign dout = '{vld: vld_s[QUOT_W-1], pt: pt_s[QUOT_W-1], ok: ok_s[QUOT_W-1],
		ovf_c: ovf_c_s[QUOT_W-1], ovf_r: ovf_r_s[QUOT_W-1],
		q_c: q_c_s[QUOT_W-1], q_r: q_r_s[QUOT_W-1]};

endmodule

@@ hdl/lidar_point_camera_projection_filter_unit.sv @@
// Pipeline from input transaction to result: 4 projection stages, 14 divider
// stages and 1 output register; all of it holds while the output is stalled.
// Throughput: one point per cycle while the output is not stalled; the 14-stage
// restoring divider produces one quotient bit per stage for column and row together.
// Reset: asynchronous, active low; clears all valid bits, matrix to zero,
// image size to 640 x 480.
// ----------------------------------------------------------------------------
// lidar_point_camera_projection_filter_unit
// Projects streamed lidar points through a 3x4 camera matrix and flags points
// that land in front of the camera and inside the image.
// ----------------------------------------------------------------------------
`include "lidar_point_camera_projection_filter_unit_macros.svh"

module lidar_point_camera_projection_filter_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lpcp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lpcp_pkg::CFG_DATA_W-1:0]        cfg_data,
	// point stream in
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [lpcp_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // point_x, point_y, point_z
	input  logic                                   s_axis_tlast,  // cloud_end
	// result stream out
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [lpcp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // pixel_col, pixel_row,
	                                                              // out_x, out_y, out_z, pad
	output logic                                   m_axis_tuser,  // keep
	output logic                                   m_axis_tlast   // out_cloud_end
);
	import lpcp_pkg::*;

	coef_mat_t         coef_q;
	logic [DIM_W-1:0]  width_q, height_q;
	logic [DIM_W-1:0]  width_lim, height_lim;

	logic              adv;
	point_t            in_pt;
	div_in_t           proj_out;
	div_out_t          div_out;

	logic              keep_n;
	logic              out_vld_q, keep_q, cend_q;
	logic [PIX_W-1:0]  col_q, row_q;
	logic signed [COORD_W-1:0] x_q, y_q, z_q;

	// Configuration registers, written in any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= '0;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ROW0_C01: begin
					coef_q[0][0] <= cfg_data[63:32];
					coef_q[0][1] <= cfg_data[31:0];
				end
				CFG_ROW0_C23: begin
					coef_q[0][2] <= cfg_data[63:32];
					coef_q[0][3] <= cfg_data[31:0];
				end
				CFG_ROW1_C01: begin
					coef_q[1][0] <= cfg_data[63:32];
					coef_q[1][1] <= cfg_data[31:0];
				end
				CFG_ROW1_C23: begin
					coef_q[1][2] <= cfg_data[63:32];
					coef_q[1][3] <= cfg_data[31:0];
				end
				CFG_ROW2_C01: begin
					coef_q[2][0] <= cfg_data[63:32];
					coef_q[2][1] <= cfg_data[31:0];
				end
				CFG_ROW2_C23: begin
					coef_q[2][2] <= cfg_data[63:32];
					coef_q[2][3] <= cfg_data[31:0];
				end
				CFG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Whole pipeline advances unless a finished result is held
	assign adv           = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv;

	assign in_pt = '{x: s_axis_tdata[31:0], y: s_axis_tdata[63:32],
		z: s_axis_tdata[95:64], cend: s_axis_tlast};

	lpcp_proj u_proj (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.coef   (coef_q),
		.in_vld (s_axis_tvalid),
		.in_pt  (in_pt),
		.dout   (proj_out)
	);

	lpcp_div_pipe u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.din    (proj_out),
		.dout   (div_out)
	);

	// Bounds test against the saturated image size
	assign width_lim  = clamp_dim(width_q);
	assign height_lim = clamp_dim(height_q);
	assign keep_n     = div_out.ok && !div_out.ovf_c && !div_out.ovf_r &&
		(div_out.q_c < width_lim) && (div_out.q_r < height_lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= div_out.vld;
		end
	end

	// Output register; pixel fields forced to zero on drop
	always_ff @(posedge clk) begin
		if (adv) begin
			keep_q <= keep_n;
			col_q  <= keep_n ? div_out.q_c[PIX_W-1:0] : '0;
			row_q  <= keep_n ? div_out.q_r[PIX_W-1:0] : '0;
			x_q    <= div_out.pt.x;
			y_q    <= div_out.pt.y;
			z_q    <= div_out.pt.z;
			cend_q <= div_out.pt.cend;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = keep_q;
	assign m_axis_tlast  = cend_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-2*PIX_W-3*COORD_W){1'b0}},
		z_q, y_q, x_q, row_q, col_q};

	// A kept pixel lies inside the image
	`LPCP_ASSERT_IMPLY(a_keep_col_inside, clk, arst_n, (out_vld_q && keep_q), ({1'b0, col_q} < width_lim))
	`LPCP_ASSERT_IMPLY(a_keep_row_inside, clk, arst_n, (out_vld_q && keep_q), ({1'b0, row_q} < height_lim))
	// A held result freezes the divider contents
	`LPCP_ASSERT_NEXT(a_stall_holds_div, clk, arst_n, (out_vld_q && !m_axis_tready), $stable(div_out))

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar point projection filter testbench
// Streams lidar points through the unit under several camera matrices and
// image sizes. Predicts every result with an exact wide-integer projection,
// checks each result field by field in order, and varies idling on both
// streams.
// ----------------------------------------------------------------------------
module testbench;
	import lpcp_pkg::*;

	localparam logic [31:0] Q_ONE = 32'h0001_0000;   // 1.0 in Q16.16
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd8;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;
	localparam int OUT_COL_LSB = 0;
	localparam int OUT_ROW_LSB = 13;
	localparam int OUT_X_LSB   = 26;
	localparam int OUT_Y_LSB   = 58;
	localparam int OUT_Z_LSB   = 90;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic              keep;
		logic [PIX_W-1:0]  col;
		logic [PIX_W-1:0]  row;
		logic [31:0]       x;
		logic [31:0]       y;
		logic [31:0]       z;
		logic              cend;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	// Predictor copy of the registers
	logic [31:0] coef_q [3][4];
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	// Geometry of the last loaded camera, used to aim points
	int cam_fx, cam_fy, cam_cx, cam_cy, cam_w, cam_h;

	pixel_result_t projection_q [$];
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int mismatch_count = 0;
	int points_sent = 0;
	int results_checked = 0;
	int kept_count = 0;
	int reg_writes = 0;

	lidar_point_camera_projection_filter_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop in case a transaction never completes
	initial begin
		#2_000_000;
		$display("timeout: stream stopped with %0d results outstanding", projection_q.size());
		$display("testbench: errors");
		$finish;
	end

	// Stall the result stream at random
	always @(negedge clk) begin
		m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 25)
			$display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
	endtask

	// Exact projection: products and sums held at full width, floor division
	function automatic pixel_result_t project_point(input logic [31:0] x, y, z,
			input logic cend);
		logic signed [69:0] pt [3];
		logic signed [69:0] acc [3];
		logic signed [69:0] qc, qr;
		logic [DIM_W-1:0] wlim, hlim;
		pixel_result_t r;
		pt[0] = $signed(x);
		pt[1] = $signed(y);
		pt[2] = $signed(z);
		for (int i = 0; i < 3; i++) begin
			acc[i] = $signed(coef_q[i][3]) * 70'sd65536;
			for (int c = 0; c < 3; c++)
				acc[i] = acc[i] + $signed(coef_q[i][c]) * pt[c];
		end
		wlim = (width_q > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : width_q;
		hlim = (height_q > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : height_q;
		r = '0;
		if (acc[2] > 0 && acc[0] >= 0 && acc[1] >= 0) begin
			qc = acc[0] / acc[2];
			qr = acc[1] / acc[2];
			if (qc < $signed({56'd0, wlim}) && qr < $signed({56'd0, hlim})) begin
				r.keep = 1'b1;
				r.col = qc[PIX_W-1:0];
				r.row = qr[PIX_W-1:0];
			end
		end
		r.x = x;
		r.y = y;
		r.z = z;
		r.cend = cend;
		return r;
	endfunction

	// Write one register and track it in the predictor copy
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		int r, c;
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx) inside
			CFG_ROW0_C01, CFG_ROW0_C23, CFG_ROW1_C01,
			CFG_ROW1_C23, CFG_ROW2_C01, CFG_ROW2_C23: begin
				r = idx[2:1];
				c = idx[0] * 2;
				coef_q[r][c] = data[63:32];
				coef_q[r][c+1] = data[31:0];
			end
			CFG_WIDTH: width_q = data[DIM_W-1:0];
			CFG_HEIGHT: height_q = data[DIM_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Present one point, hold it until taken, then queue its prediction
	task automatic send_point(input logic [31:0] x, y, z, input logic cend);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tdata = {z, y, x};
		s_axis_tlast = cend;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		projection_q.insert(projection_q.size(), project_point(x, y, z, cend));
		points_sent++;
		@(negedge clk);
	endtask

	// Hold the input until every expected result has come back
	task automatic drain_results();
		s_axis_tvalid = 1'b0;
		while (projection_q.size() != 0)
			@(negedge clk);
	endtask

	// Pinhole camera: focal lengths and center in pixels, small translation
	task automatic load_camera(input int fx, fy, cx, cy, tx, ty,
			input logic [DIM_W-1:0] w, h);
		logic [31:0] fx_q, fy_q, cx_q, cy_q;
		fx_q = fx << 16;
		fy_q = fy << 16;
		cx_q = cx << 16;
		cy_q = cy << 16;
		cfg_write(CFG_ROW0_C01, {fx_q, 32'd0});
		cfg_write(CFG_ROW0_C23, {cx_q, 32'(tx)});
		cfg_write(CFG_ROW1_C01, {32'd0, fy_q});
		cfg_write(CFG_ROW1_C23, {cy_q, 32'(ty)});
		cfg_write(CFG_ROW2_C01, 64'd0);
		cfg_write(CFG_ROW2_C23, {Q_ONE, 32'd0});
		cfg_write(CFG_WIDTH, 64'(w));
		cfg_write(CFG_HEIGHT, 64'(h));
		cam_fx = fx;
		cam_fy = fy;
		cam_cx = cx;
		cam_cy = cy;
		cam_w = (w > MAX_IMAGE_DIM) ? int'(MAX_IMAGE_DIM) : ((w == 0) ? 1 : int'(w));
		cam_h = (h > MAX_IMAGE_DIM) ? int'(MAX_IMAGE_DIM) : ((h == 0) ? 1 : int'(h));
	endtask

	task automatic load_random_camera(input logic [DIM_W-1:0] w, h);
		int ew, eh;
		ew = (w > MAX_IMAGE_DIM) ? int'(MAX_IMAGE_DIM) : int'(w);
		eh = (h > MAX_IMAGE_DIM) ? int'(MAX_IMAGE_DIM) : int'(h);
		load_camera(ew / 2 + int'($urandom_range(ew)) + 1, eh / 2 + int'($urandom_range(eh)) + 1,
			ew / 2, eh / 2, int'($urandom_range(2048)) - 1024,
			int'($urandom_range(2048)) - 1024, w, h);
	endtask

	function automatic logic [31:0] extreme_word();
		case ($urandom_range(4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return Q_ONE;
		endcase
	endfunction

	// Mostly points aimed around the image, the rest raw noise
	task automatic random_points(input int n);
		longint zq, xq, yq;
		int tc, tr;
		logic [31:0] x, y, z;
		for (int k = 0; k < n; k++) begin
			if (k == n / 2)
				drain_results();
			if ($urandom_range(99) < 80) begin
				zq = longint'($urandom_range(80 << 16, 1 << 15));
				if ($urandom_range(9) == 0)
					zq = -zq;
				tc = int'($urandom_range(cam_w + cam_w / 4)) - cam_w / 8;
				tr = int'($urandom_range(cam_h + cam_h / 4)) - cam_h / 8;
				xq = (longint'(tc - cam_cx) * zq) / cam_fx + int'($urandom_range(255)) - 128;
				yq = (longint'(tr - cam_cy) * zq) / cam_fy + int'($urandom_range(255)) - 128;
				x = xq[31:0];
				y = yq[31:0];
				z = zq[31:0];
			end else if ($urandom_range(3) == 0) begin
				x = extreme_word();
				y = extreme_word();
				z = extreme_word();
			end else begin
				x = $urandom;
				y = $urandom;
				z = $urandom;
			end
			send_point(x, y, z, $urandom_range(15) == 0);
		end
	endtask

	// Pick one of several register settings for the next stretch of points
	task automatic random_setup(input int kind);
		case (kind)
			0: load_random_camera(14'd640, 14'd480);
			1: load_random_camera(DIM_W'($urandom_range(8192, 1)), DIM_W'($urandom_range(8192, 1)));
			2: load_random_camera(DIM_W'($urandom_range(16383, 8193)),
				DIM_W'($urandom_range(16383, 8193)));
			3: load_random_camera(DIM_W'($urandom_range(16, 1)), DIM_W'($urandom_range(16, 1)));
			4: begin
				for (int i = 0; i < 6; i++)
					cfg_write(CFG_IDX_W'(CFG_ROW0_C01 + i), {$urandom, $urandom});
				cfg_write(CFG_WIDTH, 64'($urandom_range(16383)));
				cfg_write(CFG_HEIGHT, 64'($urandom_range(16383)));
			end
			default: begin
				for (int i = 0; i < 6; i++)
					cfg_write(CFG_IDX_W'(CFG_ROW0_C01 + i), {extreme_word(), extreme_word()});
				cfg_write(CFG_WIDTH, 64'(MAX_IMAGE_DIM));
				cfg_write(CFG_HEIGHT, 64'(MAX_IMAGE_DIM));
			end
		endcase
	endtask

	// Compare each result with the oldest prediction
	always @(posedge clk) begin : result_check
		pixel_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (projection_q.size() == 0) begin
				report_mismatch("result with none expected, col", 32'(m_axis_tdata[12:0]), 0);
			end else begin
				want = projection_q.pop_front();
				results_checked++;
				if (want.keep)
					kept_count++;
				if (m_axis_tuser !== want.keep)
					report_mismatch("keep", 32'(m_axis_tuser), 32'(want.keep));
				if (m_axis_tdata[OUT_COL_LSB +: PIX_W] !== want.col)
					report_mismatch("pixel_col", 32'(m_axis_tdata[OUT_COL_LSB +: PIX_W]),
						32'(want.col));
				if (m_axis_tdata[OUT_ROW_LSB +: PIX_W] !== want.row)
					report_mismatch("pixel_row", 32'(m_axis_tdata[OUT_ROW_LSB +: PIX_W]),
						32'(want.row));
				if (m_axis_tdata[OUT_X_LSB +: 32] !== want.x)
					report_mismatch("out_x", m_axis_tdata[OUT_X_LSB +: 32], want.x);
				if (m_axis_tdata[OUT_Y_LSB +: 32] !== want.y)
					report_mismatch("out_y", m_axis_tdata[OUT_Y_LSB +: 32], want.y);
				if (m_axis_tdata[OUT_Z_LSB +: 32] !== want.z)
					report_mismatch("out_z", m_axis_tdata[OUT_Z_LSB +: 32], want.z);
				if (m_axis_tlast !== want.cend)
					report_mismatch("out_cloud_end", 32'(m_axis_tlast), 32'(want.cend));
			end
		end
	end

	// Zero matrix after reset: depth is zero, nothing is kept
	task automatic test_reset_state();
		send_point($urandom, $urandom, $urandom, 1'b0);
		send_point(32'd0, 32'd0, Q_ONE, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		drain_results();
	endtask

	// Boundaries with fx = fy = 512 and center (320, 240) on a 640 x 480 image
	task automatic test_camera_edges();
		load_camera(512, 512, 320, 240, 0, 0, 14'd640, 14'd480);
		send_point(32'd0, 32'd0, Q_ONE, 1'b0);                // image center
		send_point(32'd40959, 32'd30719, Q_ONE, 1'b0);        // last column and row
		send_point(32'd40960, 32'd0, Q_ONE, 1'b0);            // column equals width
		send_point(32'd0, 32'd30720, Q_ONE, 1'b1);            // row equals height
		send_point(-32'sd40960, -32'sd30720, Q_ONE, 1'b0);    // column and row zero
		send_point(-32'sd40961, 32'd0, Q_ONE, 1'b0);          // negative column
		send_point(32'd0, -32'sd30721, Q_ONE, 1'b0);          // negative row
		send_point(32'd0, 32'd0, 32'd0, 1'b0);                // zero depth
		send_point(32'd0, 32'd0, -Q_ONE, 1'b1);               // behind the camera
		send_point(32'd0, 32'd0, 32'd1, 1'b0);                // tiny depth
		send_point(32'h7FFF_FFFF, 32'd0, 32'd1, 1'b0);        // quotient overflow
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		drain_results();
	endtask

	// Identity matrix: pixel equals x and y in Q16.16 pixels at depth 1.0
	task automatic test_image_limits();
		cfg_write(CFG_ROW0_C01, {Q_ONE, 32'd0});
		cfg_write(CFG_ROW0_C23, 64'd0);
		cfg_write(CFG_ROW1_C01, {32'd0, Q_ONE});
		cfg_write(CFG_ROW1_C23, 64'd0);
		cfg_write(CFG_ROW2_C01, 64'd0);
		cfg_write(CFG_ROW2_C23, {Q_ONE, 32'd0});
		cfg_write(CFG_WIDTH, 64'(MAX_IMAGE_DIM));
		cfg_write(CFG_HEIGHT, 64'(MAX_IMAGE_DIM));
		send_point(32'h1FFF_8000, 32'h1FFF_FFFF, Q_ONE, 1'b0);
		send_point(32'h2000_0000, 32'd0, Q_ONE, 1'b0);
		drain_results();
		// Sizes above the maximum saturate; spare indexes change nothing
		cfg_write(CFG_WIDTH, 64'd16383);
		cfg_write(CFG_HEIGHT, 64'd9000);
		cfg_write(CFG_SPARE_LO, {$urandom, $urandom});
		cfg_write(CFG_SPARE_HI, 64'hFFFF_FFFF_FFFF_FFFF);
		send_point(32'h1FFF_0000, 32'h1FFF_0000, Q_ONE, 1'b0);
		send_point(32'h2000_0000, 32'd0, Q_ONE, 1'b0);
		send_point(32'd0, 32'h2000_0000, Q_ONE, 1'b1);
		drain_results();
		// Zero width, then zero height
		cfg_write(CFG_WIDTH, 64'd0);
		send_point(32'd0, 32'd0, Q_ONE, 1'b0);
		drain_results();
		cfg_write(CFG_WIDTH, 64'd1);
		cfg_write(CFG_HEIGHT, 64'd0);
		send_point(32'd0, 32'd0, Q_ONE, 1'b0);
		drain_results();
		// Single-pixel image
		cfg_write(CFG_HEIGHT, 64'd1);
		send_point(32'h0000_8000, 32'h0000_8000, Q_ONE, 1'b0);
		send_point(Q_ONE, 32'd0, Q_ONE, 1'b1);
		drain_results();
	endtask

	task automatic test_random_stream(input int tx_pct, input int rx_pct, input int n_items);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int seg = 0; seg < 6; seg++) begin
			drain_results();
			random_setup(seg);
			random_points(n_items / 6);
		end
		drain_results();
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int i = 0; i < 3; i++)
			for (int c = 0; c < 4; c++)
				coef_q[i][c] = '0;
		width_q = WIDTH_RESET;
		height_q = HEIGHT_RESET;

		test_reset_state();
		test_camera_edges();
		test_image_limits();
		test_random_stream(26, 55, 636);
		test_random_stream(55, 26, 636);
		test_random_stream(0, 0, 636);

		// Let the pipeline settle and catch any stray result
		s_axis_tvalid = 1'b0;
		while (projection_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d points sent, %0d results checked, %0d kept, %0d register writes",
			points_sent, results_checked, kept_count, reg_writes);
		$display("summary: camera edges, image size limits, random matrices under three idle mixes");
		if (mismatch_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
